FILE: sv/gff_pkg.sv
// ----------------------------------------------------------------------------
// gff_pkg
// Shared sizes, codes, queue entry type and helpers for the grid flood fill.
// ----------------------------------------------------------------------------
package gff_pkg;

    // grid limits
    localparam int MAX_ROWS  = 64;
    localparam int MAX_COLS  = 64;
    localparam int ROW_W     = $clog2(MAX_ROWS);
    localparam int COL_W     = $clog2(MAX_COLS);
    localparam int ROW_CNT_W = $clog2(MAX_ROWS + 1);
    localparam int COL_CNT_W = $clog2(MAX_COLS + 1);

    // configuration port
    localparam int CFG_W   = 7;
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_COLS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ROWS = 1'b1;
    localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

    // cell kinds
    localparam logic [1:0] KIND_FREE   = 2'd0;
    localparam logic [1:0] KIND_WALL   = 2'd1;
    localparam logic [1:0] KIND_TARGET = 2'd2;
    localparam logic [1:0] KIND_START  = 2'd3;

    // result codes
    localparam logic [1:0] CODE_ALL     = 2'd0;
    localparam logic [1:0] CODE_MISS    = 2'd1;
    localparam logic [1:0] CODE_NOSTART = 2'd2;

    // cell queue between loader and flood engine
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef struct packed {
        logic             store;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic [1:0]       kind;
        logic             last;
        logic             seen;
        logic [ROW_W-1:0] srow;
        logic [COL_W-1:0] scol;
    } cell_entry_t;

    // size register to active count: zero acts as one, large acts as max
    function automatic logic [ROW_CNT_W-1:0] clamp_rows(input logic [CFG_W-1:0] v);
        logic [31:0] t;
        begin
            t = {{(32-CFG_W){1'b0}}, v};
            if (t == 32'd0)
                t = 32'd1;
            else if (t > MAX_ROWS)
                t = MAX_ROWS;
            return t[ROW_CNT_W-1:0];
        end
    endfunction

    function automatic logic [COL_CNT_W-1:0] clamp_cols(input logic [CFG_W-1:0] v);
        logic [31:0] t;
        begin
            t = {{(32-CFG_W){1'b0}}, v};
            if (t == 32'd0)
                t = 32'd1;
            else if (t > MAX_COLS)
                t = MAX_COLS;
            return t[COL_CNT_W-1:0];
        end
    endfunction

endpackage

FILE: sv/gff_ram.sv
// ----------------------------------------------------------------------------
// gff_ram
// Generic single write, single read RAM with per-bit write mask and
// registered read data.
// ----------------------------------------------------------------------------
module gff_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [WIDTH-1:0]         wmask,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // masked write
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= (mem[waddr] & ~wmask) | (wdata & wmask);
        end
    end

    // registered read
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

FILE: sv/gff_front.sv
// ----------------------------------------------------------------------------
// gff_front
// Cell loader: tracks the row-major load position, finds the first start
// cell and pushes one queue entry per accepted cell.
// ----------------------------------------------------------------------------
module gff_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [1:0]                    cell_kind,
    input  logic                          last_cell,
    input  logic [gff_pkg::ROW_CNT_W-1:0] rows,
    input  logic [gff_pkg::COL_CNT_W-1:0] cols,
    input  logic                          q_full,
    output logic                          busy,
    output logic                          push,
    output gff_pkg::cell_entry_t          entry
);

    localparam logic [gff_pkg::ROW_CNT_W-1:0] ROW_ONE = {{(gff_pkg::ROW_CNT_W-1){1'b0}}, 1'b1};
    localparam logic [gff_pkg::COL_CNT_W-1:0] COL_ONE = {{(gff_pkg::COL_CNT_W-1){1'b0}}, 1'b1};

    logic [gff_pkg::ROW_CNT_W-1:0] load_row_reg, load_row_next;
    logic [gff_pkg::COL_CNT_W-1:0] load_col_reg, load_col_next;
    logic                          seen_reg, seen_next;
    logic [gff_pkg::ROW_W-1:0]     srow_reg, srow_next;
    logic [gff_pkg::COL_W-1:0]     scol_reg, scol_next;

    logic [gff_pkg::ROW_CNT_W-1:0] lr;
    logic [gff_pkg::COL_CNT_W-1:0] lc;
    logic [gff_pkg::ROW_W-1:0]     cell_row;
    logic [gff_pkg::COL_W-1:0]     cell_col;
    logic                          store;

    assign busy = q_full;
    assign push = start && !q_full;

    // position update for one cell
    always_comb
    begin
        lr        = load_row_reg;
        lc        = load_col_reg;
        seen_next = seen_reg;
        srow_next = srow_reg;
        scol_next = scol_reg;
        cell_row  = '0;
        cell_col  = '0;
        if (lc >= cols)
        begin
            lc = '0;
            if (lr < rows)
                lr = lr + ROW_ONE;
        end
        store = (lr < rows);
        if (store)
        begin
            cell_row = lr[gff_pkg::ROW_W-1:0];
            cell_col = lc[gff_pkg::COL_W-1:0];
            if (cell_kind == gff_pkg::KIND_START && !seen_reg)
            begin
                seen_next = 1'b1;
                srow_next = cell_row;
                scol_next = cell_col;
            end
            lc = lc + COL_ONE;
            if (lc >= cols)
            begin
                lc = '0;
                lr = lr + ROW_ONE;
            end
        end
        load_row_next = last_cell ? '0 : lr;
        load_col_next = last_cell ? '0 : lc;

        entry.store = store;
        entry.row   = cell_row;
        entry.col   = cell_col;
        entry.kind  = cell_kind;
        entry.last  = last_cell;
        entry.seen  = seen_next;
        entry.srow  = srow_next;
        entry.scol  = scol_next;
    end

    // load state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_row_reg <= '0;
            load_col_reg <= '0;
            seen_reg     <= 1'b0;
            srow_reg     <= '0;
            scol_reg     <= '0;
        end
        else if (push)
        begin
            load_row_reg <= load_row_next;
            load_col_reg <= load_col_next;
            seen_reg     <= last_cell ? 1'b0 : seen_next;
            srow_reg     <= srow_next;
            scol_reg     <= scol_next;
        end
    end

endmodule

FILE: sv/gff_queue.sv
// ----------------------------------------------------------------------------
// gff_queue
// Short FIFO of cell entries between loader and flood engine.
// ----------------------------------------------------------------------------
module gff_queue (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    input  gff_pkg::cell_entry_t        push_entry,
    input  logic                        pop,
    output gff_pkg::cell_entry_t        head,
    output logic                        empty,
    output logic                        full,
    output logic [gff_pkg::Q_CNT_W-1:0] count
);

    localparam logic [gff_pkg::Q_CNT_W-1:0] CNT_ONE  = {{(gff_pkg::Q_CNT_W-1){1'b0}}, 1'b1};
    localparam logic [gff_pkg::Q_CNT_W-1:0] CNT_FULL = gff_pkg::Q_CNT_W'(gff_pkg::Q_DEPTH);
    localparam logic [gff_pkg::Q_PTR_W-1:0] PTR_ONE  = {{(gff_pkg::Q_PTR_W-1){1'b0}}, 1'b1};

    gff_pkg::cell_entry_t             slots [gff_pkg::Q_DEPTH];
    logic [gff_pkg::Q_PTR_W-1:0]      wr_ptr_reg, rd_ptr_reg;
    logic [gff_pkg::Q_CNT_W-1:0]      count_reg;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == CNT_FULL);
    assign count = count_reg;
    assign head  = slots[rd_ptr_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
            slots[wr_ptr_reg] <= push_entry;
    end

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + PTR_ONE;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + PTR_ONE;
            if (push && !pop)
                count_reg <= count_reg + CNT_ONE;
            else if (pop && !push)
                count_reg <= count_reg - CNT_ONE;
        end
    end

endmodule

FILE: sv/gff_back.sv
// ----------------------------------------------------------------------------
// gff_back
// Flood engine: stores queued cells into wall/target row RAMs, then floods
// with alternating down and up row sweeps until two sweeps in a row change
// nothing, and reports the check code.
// ----------------------------------------------------------------------------
module gff_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [gff_pkg::ROW_CNT_W-1:0] rows,
    input  logic [gff_pkg::COL_CNT_W-1:0] cols,
    input  gff_pkg::cell_entry_t          head,
    input  logic                          q_empty,
    output logic                          pop,
    output logic                          done,
    output logic [1:0]                    check_code
);

    localparam int W = gff_pkg::MAX_COLS;
    localparam logic [gff_pkg::ROW_W-1:0] ROW_ONE = {{(gff_pkg::ROW_W-1){1'b0}}, 1'b1};
    localparam logic [W-1:0] BIT_ONE = {{(W-1){1'b0}}, 1'b1};

    typedef enum logic [1:0] {
        ST_LOAD  = 2'b01,
        ST_FLOOD = 2'b10
    } state_t;

    state_t                    state_reg, state_next;
    logic [gff_pkg::ROW_W-1:0] iss_row_reg, iss_row_next;
    logic                      iss_on_reg, iss_on_next;
    logic                      vld_reg, vld_next;
    logic [gff_pkg::ROW_W-1:0] prc_row_reg, prc_row_next;
    logic                      dir_up_reg, dir_up_next;
    logic                      first_reg, first_next;
    logic                      chg_reg, chg_next;
    logic                      miss_reg, miss_next;
    logic                      quiet_reg, quiet_next;
    logic [W-1:0]              prev_reg, prev_next;
    logic [gff_pkg::ROW_W-1:0] srow_reg, srow_next;
    logic [gff_pkg::COL_W-1:0] scol_reg, scol_next;
    logic                      done_reg, done_next;
    logic [1:0]                code_reg, code_next;

    logic [W-1:0] wall_q, tgt_q, reach_q;
    logic [W-1:0] col_mask, open, old_row, seed, new_row, cell_bit;
    logic [W-1:0] open_rv, seed_rv, down_rv, up_fill, down_fill;
    logic [W:0]   sum_up, sum_dn;
    logic [W-1:0] carry_up, carry_dn;
    logic [gff_pkg::ROW_W-1:0] end_row, last_row;
    logic         row_chg, row_miss, pass_chg, pass_miss, start_ok;
    logic         cell_we, reach_we;

    assign last_row = gff_pkg::ROW_W'(rows - 1'b1);
    assign end_row  = dir_up_reg ? '0 : last_row;

    // row RAMs
    assign pop      = (state_reg == ST_LOAD) && !q_empty;
    assign cell_we  = pop && head.store;
    assign cell_bit = BIT_ONE << head.col;

    gff_ram #(.WIDTH(W), .DEPTH(gff_pkg::MAX_ROWS)) u_wall (
        .clk(clk), .we(cell_we), .waddr(head.row),
        .wdata({W{head.kind == gff_pkg::KIND_WALL}}), .wmask(cell_bit),
        .raddr(iss_row_reg), .rdata(wall_q)
    );

    gff_ram #(.WIDTH(W), .DEPTH(gff_pkg::MAX_ROWS)) u_target (
        .clk(clk), .we(cell_we), .waddr(head.row),
        .wdata({W{head.kind == gff_pkg::KIND_TARGET}}), .wmask(cell_bit),
        .raddr(iss_row_reg), .rdata(tgt_q)
    );

    gff_ram #(.WIDTH(W), .DEPTH(gff_pkg::MAX_ROWS)) u_reach (
        .clk(clk), .we(reach_we), .waddr(prc_row_reg),
        .wdata(new_row), .wmask({W{1'b1}}),
        .raddr(iss_row_reg), .rdata(reach_q)
    );

    // active column mask
    always_comb
    begin
        for (int i = 0; i < W; i++)
            col_mask[i] = (i < int'(cols));
    end

    // row fill: seeds spread through open runs by carry chains both ways
    always_comb
    begin
        open    = ~wall_q & col_mask;
        old_row = first_reg ? '0 : reach_q;
        seed    = (old_row | prev_reg
                   | ((prc_row_reg == srow_reg) ? (BIT_ONE << scol_reg) : '0)) & open;
        for (int i = 0; i < W; i++)
        begin
            open_rv[i] = open[W-1-i];
            seed_rv[i] = seed[W-1-i];
        end
        sum_up    = {1'b0, open} + {1'b0, seed};
        carry_up  = sum_up[W-1:0] ^ open ^ seed;
        up_fill   = seed | (open & carry_up);
        sum_dn    = {1'b0, open_rv} + {1'b0, seed_rv};
        carry_dn  = sum_dn[W-1:0] ^ open_rv ^ seed_rv;
        down_rv   = seed_rv | (open_rv & carry_dn);
        for (int i = 0; i < W; i++)
            down_fill[i] = down_rv[W-1-i];
        new_row   = up_fill | down_fill;
        row_chg   = (new_row != old_row);
        row_miss  = |(tgt_q & col_mask & ~new_row);
        pass_chg  = chg_reg | row_chg;
        pass_miss = miss_reg | row_miss;
    end

    assign reach_we = (state_reg == ST_FLOOD) && vld_reg;
    assign start_ok = head.seen && ({1'b0, head.srow} < rows) && ({1'b0, head.scol} < cols);

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        iss_row_next = iss_row_reg;
        iss_on_next  = iss_on_reg;
        vld_next     = 1'b0;
        prc_row_next = prc_row_reg;
        dir_up_next  = dir_up_reg;
        first_next   = first_reg;
        chg_next     = chg_reg;
        miss_next    = miss_reg;
        quiet_next   = quiet_reg;
        prev_next    = prev_reg;
        srow_next    = srow_reg;
        scol_next    = scol_reg;
        done_next    = 1'b0;
        code_next    = code_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (pop && head.last)
                begin
                    if (!start_ok)
                    begin
                        done_next = 1'b1;
                        code_next = gff_pkg::CODE_NOSTART;
                    end
                    else
                    begin
                        state_next   = ST_FLOOD;
                        srow_next    = head.srow;
                        scol_next    = head.scol;
                        iss_row_next = '0;
                        iss_on_next  = 1'b1;
                        dir_up_next  = 1'b0;
                        first_next   = 1'b1;
                        chg_next     = 1'b0;
                        miss_next    = 1'b0;
                        quiet_next   = 1'b0;
                        prev_next    = '0;
                    end
                end
            end
            ST_FLOOD:
            begin
                // issue row reads
                if (iss_on_reg)
                begin
                    vld_next     = 1'b1;
                    prc_row_next = iss_row_reg;
                    if (iss_row_reg == end_row)
                        iss_on_next = 1'b0;
                    else if (dir_up_reg)
                        iss_row_next = iss_row_reg - ROW_ONE;
                    else
                        iss_row_next = iss_row_reg + ROW_ONE;
                end
                // process returned row
                if (vld_reg)
                begin
                    prev_next = new_row;
                    chg_next  = pass_chg;
                    miss_next = pass_miss;
                    if (prc_row_reg == end_row)
                    begin
                        if (!pass_chg && quiet_reg)
                        begin
                            state_next = ST_LOAD;
                            done_next  = 1'b1;
                            code_next  = pass_miss ? gff_pkg::CODE_MISS : gff_pkg::CODE_ALL;
                        end
                        else
                        begin
                            quiet_next   = !pass_chg;
                            dir_up_next  = !dir_up_reg;
                            first_next   = 1'b0;
                            prev_next    = '0;
                            chg_next     = 1'b0;
                            miss_next    = 1'b0;
                            iss_on_next  = 1'b1;
                            iss_row_next = dir_up_reg ? '0 : last_row;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_LOAD;
            iss_on_reg <= 1'b0;
            vld_reg    <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            iss_on_reg <= iss_on_next;
            vld_reg    <= vld_next;
            done_reg   <= done_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        iss_row_reg <= iss_row_next;
        prc_row_reg <= prc_row_next;
        dir_up_reg  <= dir_up_next;
        first_reg   <= first_next;
        chg_reg     <= chg_next;
        miss_reg    <= miss_next;
        quiet_reg   <= quiet_next;
        prev_reg    <= prev_next;
        srow_reg    <= srow_next;
        scol_reg    <= scol_next;
        code_reg    <= code_next;
    end

    assign done       = done_reg;
    assign check_code = code_reg;

endmodule

FILE: sv/grid_flood_fill_reachability.sv
// ----------------------------------------------------------------------------
// grid_flood_fill_reachability
// Loads a grid one cell per transaction and checks that every target is
// four-connected to the first start cell.
// ----------------------------------------------------------------------------
//  channel   | handshake          | payload
//  ----------+--------------------+---------------------------
//  cell in   | start & !busy      | cell_kind, last_cell
//  result    | done (one cycle)   | check_code
//  config    | cfg_we             | cfg_index, cfg_data
//
//  Cells are taken one per cycle; busy rises only when the 4-entry cell
//  queue is full, which happens while the flood engine is sweeping.
//  After the last cell, the flood runs alternating row sweeps (down, up,
//  down, ...) until two sweeps in a row change nothing, then raises the
//  done strobe. No start cell: done comes in the cycle after the last
//  cell is dequeued.
//  Reset clears control state; wall and target rows hold stale data.
//  done cannot be stalled: the receiver takes the result in its cycle.
// ----------------------------------------------------------------------------
module grid_flood_fill_reachability (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    cell_kind,
    input  logic                          last_cell,
    output logic                          done,
    output logic [1:0]                    check_code,
    input  logic                          cfg_we,
    input  logic [gff_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [gff_pkg::CFG_W-1:0]     cfg_data
);

    logic [gff_pkg::CFG_W-1:0]     cols_reg, rows_reg;
    logic [gff_pkg::ROW_CNT_W-1:0] rows;
    logic [gff_pkg::COL_CNT_W-1:0] cols;

    logic                          push, pop, q_empty, q_full;
    logic [gff_pkg::Q_CNT_W-1:0]   q_count;
    gff_pkg::cell_entry_t          push_entry, head;

    // size registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg <= gff_pkg::CFG_RESET;
            rows_reg <= gff_pkg::CFG_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == gff_pkg::REG_COLS)
                cols_reg <= cfg_data;
            if (cfg_index == gff_pkg::REG_ROWS)
                rows_reg <= cfg_data;
        end
    end

    assign rows = gff_pkg::clamp_rows(rows_reg);
    assign cols = gff_pkg::clamp_cols(cols_reg);

    gff_front u_front (
        .clk(clk), .rst_n(rst_n), .start(start), .cell_kind(cell_kind),
        .last_cell(last_cell), .rows(rows), .cols(cols), .q_full(q_full),
        .busy(busy), .push(push), .entry(push_entry)
    );

    gff_queue u_queue (
        .clk(clk), .rst_n(rst_n), .push(push), .push_entry(push_entry),
        .pop(pop), .head(head), .empty(q_empty), .full(q_full), .count(q_count)
    );

    gff_back u_back (
        .clk(clk), .rst_n(rst_n), .rows(rows), .cols(cols), .head(head),
        .q_empty(q_empty), .pop(pop), .done(done), .check_code(check_code)
    );

    // checks
    a_code_legal: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (check_code == gff_pkg::CODE_ALL || check_code == gff_pkg::CODE_MISS
                  || check_code == gff_pkg::CODE_NOSTART))
        else $error("done with illegal check code");

    a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_count <= gff_pkg::Q_CNT_W'(gff_pkg::Q_DEPTH))
        else $error("cell queue overflow");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_empty)
        else $error("pop from empty cell queue");

    a_full_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop && q_count == gff_pkg::Q_CNT_W'(gff_pkg::Q_DEPTH - 1)) |=> busy)
        else $error("queue filled without busy");

endmodule
